>>> hw/rtl/lpld_pkg.sv
// Package for the length-prefixed line deframer: limits, byte codes and
// the frame status type. No dependencies.
`default_nettype none

package lpld_pkg;

    localparam int MAX_PAYLOAD   = 4096;
    localparam int MAX_LEN_CHARS = 10;

    // char_count must hold MAX_PAYLOAD itself
    localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 16;

    localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'd10;
    localparam logic [BYTE_W-1:0] NUL_BYTE     = 8'd0;
    localparam logic [BYTE_W-1:0] DIGIT_ZERO   = 8'd48;
    localparam logic [BYTE_W-1:0] DIGIT_NINE   = 8'd57;

    typedef enum logic [1:0] {
        STATUS_GOOD     = 2'd0,
        STATUS_MISMATCH = 2'd1,
        STATUS_OVERFLOW = 2'd2
    } status_t;

endpackage

`default_nettype wire

>>> hw/rtl/length_prefixed_line_deframer.sv
// Length-prefixed line deframer, top level and only module.
// Depends on lpld_pkg for limits, byte codes and status_t.
//
// The block takes one stream byte per request on the s_ channel and gives
// at most one result per byte on the m_ channel. A frame is a decimal
// length line, a newline, then a payload line closed by a newline. Each
// payload byte comes out as a payload request (m_frame_end = 0); the
// closing newline gives one end request (m_frame_end = 1) carrying the
// status (good, length mismatch, overflow discarded) and the declared
// length, the leading digits of the length line modulo 65536. Payload
// length for the mismatch check counts bytes up to the first zero byte.
// A length line longer than MAX_LEN_CHARS or a payload longer than
// MAX_PAYLOAD sends the frame into discard until the next newline, which
// ends it with overflow status. Leading and repeated newlines are skipped.
// Rate: one byte per clock, sustained. The whole per-byte update of the
// frame state is one register-to-register step, and the result lands in
// a single output register; s_ready is high whenever that register is
// empty or is being drained in the same cycle, so bytes stream at full
// rate as long as the sink keeps m_ready high. Where an accepted byte
// gives a result, it is on m_ in the cycle after the byte is accepted.
`default_nettype none

module length_prefixed_line_deframer (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [lpld_pkg::BYTE_W-1:0]  s_in_byte,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic      [lpld_pkg::BYTE_W-1:0]  m_out_byte,
    output logic                              m_frame_end,
    output logic      [1:0]                   m_frame_status,
    output logic      [lpld_pkg::LEN_W-1:0]   m_declared_length
);

    // ---------------- frame state ----------------
    logic                          in_payload_reg,    in_payload_next;
    logic                          line_started_reg,  line_started_next;
    logic                          after_newline_reg, after_newline_next;
    logic                          overflowed_reg,    overflowed_next;
    logic                          digits_ended_reg,  digits_ended_next;
    logic [lpld_pkg::CNT_W-1:0]    char_count_reg,    char_count_next;
    logic [lpld_pkg::LEN_W-1:0]    length_value_reg,  length_value_next;
    logic [lpld_pkg::LEN_W-1:0]    payload_count_reg, payload_count_next;
    logic                          zero_seen_reg,     zero_seen_next;

    // ---------------- output register ----------------
    logic                          m_valid_reg;
    logic [lpld_pkg::BYTE_W-1:0]   out_byte_reg;
    logic                          frame_end_reg;
    lpld_pkg::status_t             frame_status_reg;
    logic [lpld_pkg::LEN_W-1:0]    declared_length_reg;

    // result of the byte on the input this cycle
    logic                          res_valid;
    logic                          res_end;
    lpld_pkg::status_t             res_status;
    logic [lpld_pkg::LEN_W-1:0]    res_length;

    logic                          s_fire;
    logic                          m_fire;
    logic                          is_newline;
    logic                          is_digit;
    logic                          is_nul;
    logic [lpld_pkg::LEN_W-1:0]    digit_value;
    logic [lpld_pkg::LEN_W-1:0]    length_times_ten;

    // Output slot frees up when empty or drained this cycle.
    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;
    assign m_fire  = m_valid_reg && m_ready;

    assign is_newline  = (s_in_byte == lpld_pkg::NEWLINE_BYTE);
    assign is_nul      = (s_in_byte == lpld_pkg::NUL_BYTE);
    assign is_digit    = (s_in_byte >= lpld_pkg::DIGIT_ZERO) &&
                         (s_in_byte <= lpld_pkg::DIGIT_NINE);
    assign digit_value = {{(lpld_pkg::LEN_W-4){1'b0}},
                          s_in_byte[3:0] - lpld_pkg::DIGIT_ZERO[3:0]};
    // x*10 = x*8 + x*2, wraps modulo 2^16
    assign length_times_ten = {length_value_reg[lpld_pkg::LEN_W-4:0], 3'b000} +
                              {length_value_reg[lpld_pkg::LEN_W-2:0], 1'b0};

    // Per-byte frame update; only committed on an accepted request.
    always_comb begin
        in_payload_next    = in_payload_reg;
        line_started_next  = line_started_reg;
        after_newline_next = after_newline_reg;
        overflowed_next    = overflowed_reg;
        digits_ended_next  = digits_ended_reg;
        char_count_next    = char_count_reg;
        length_value_next  = length_value_reg;
        payload_count_next = payload_count_reg;
        zero_seen_next     = zero_seen_reg;
        res_valid          = 1'b0;
        res_end            = 1'b0;
        res_status         = lpld_pkg::STATUS_GOOD;
        res_length         = length_value_reg;

        if (overflowed_reg) begin
            // discard until newline
            if (is_newline) begin
                res_valid  = 1'b1;
                res_end    = 1'b1;
                res_status = lpld_pkg::STATUS_OVERFLOW;
            end
        end else if (!is_newline) begin
            line_started_next  = 1'b1;
            after_newline_next = 1'b0;
            if (!in_payload_reg) begin
                if (char_count_reg >= lpld_pkg::CNT_W'(lpld_pkg::MAX_LEN_CHARS)) begin
                    overflowed_next = 1'b1;
                end else begin
                    char_count_next = char_count_reg + lpld_pkg::CNT_W'(1);
                    if (!digits_ended_reg && is_digit) begin
                        length_value_next = length_times_ten + digit_value;
                    end else begin
                        digits_ended_next = 1'b1;
                    end
                end
            end else begin
                if (char_count_reg >= lpld_pkg::CNT_W'(lpld_pkg::MAX_PAYLOAD)) begin
                    overflowed_next = 1'b1;
                end else begin
                    char_count_next = char_count_reg + lpld_pkg::CNT_W'(1);
                    zero_seen_next  = zero_seen_reg || is_nul;
                    if (!(zero_seen_reg || is_nul)) begin
                        payload_count_next = payload_count_reg + lpld_pkg::LEN_W'(1);
                    end
                    res_valid = 1'b1;
                end
            end
        end else if (line_started_reg && !after_newline_reg) begin
            if (!in_payload_reg) begin
                in_payload_next    = 1'b1;
                char_count_next    = '0;
                after_newline_next = 1'b1;
            end else begin
                res_valid  = 1'b1;
                res_end    = 1'b1;
                res_status = (payload_count_reg == length_value_reg) ?
                             lpld_pkg::STATUS_GOOD : lpld_pkg::STATUS_MISMATCH;
            end
        end

        // an end request closes the frame
        if (res_end) begin
            in_payload_next    = 1'b0;
            line_started_next  = 1'b0;
            after_newline_next = 1'b0;
            overflowed_next    = 1'b0;
            digits_ended_next  = 1'b0;
            char_count_next    = '0;
            length_value_next  = '0;
            payload_count_next = '0;
            zero_seen_next     = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_payload_reg    <= 1'b0;
            line_started_reg  <= 1'b0;
            after_newline_reg <= 1'b0;
            overflowed_reg    <= 1'b0;
            digits_ended_reg  <= 1'b0;
            char_count_reg    <= '0;
            length_value_reg  <= '0;
            payload_count_reg <= '0;
            zero_seen_reg     <= 1'b0;
        end else if (s_fire) begin
            in_payload_reg    <= in_payload_next;
            line_started_reg  <= line_started_next;
            after_newline_reg <= after_newline_next;
            overflowed_reg    <= overflowed_next;
            digits_ended_reg  <= digits_ended_next;
            char_count_reg    <= char_count_next;
            length_value_reg  <= length_value_next;
            payload_count_reg <= payload_count_next;
            zero_seen_reg     <= zero_seen_next;
        end
    end

    // output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire) begin
            m_valid_reg <= res_valid;
        end else if (m_fire) begin
            m_valid_reg <= 1'b0;
        end
    end

    // output payload, no reset
    always_ff @(posedge aclk) begin
        if (s_fire && res_valid) begin
            out_byte_reg        <= res_end ? lpld_pkg::NUL_BYTE : s_in_byte;
            frame_end_reg       <= res_end;
            frame_status_reg    <= res_status;
            declared_length_reg <= res_end ? res_length : '0;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_out_byte        = out_byte_reg;
    assign m_frame_end       = frame_end_reg;
    assign m_frame_status    = frame_status_reg;
    assign m_declared_length = declared_length_reg;

`ifndef ASSERT_OFF
    // end requests carry no byte; payload requests carry no status or length
    a_end_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && frame_end_reg) |-> (out_byte_reg == lpld_pkg::NUL_BYTE))
        else $error("end request with nonzero byte");

    a_payload_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !frame_end_reg) |->
        (frame_status_reg == lpld_pkg::STATUS_GOOD && declared_length_reg == '0))
        else $error("payload request with status or length");

    // an end request leaves the frame state cleared
    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && res_end) |=>
        (!in_payload_reg && !overflowed_reg && char_count_reg == '0 &&
         payload_count_reg == '0))
        else $error("frame state not cleared after end");

    // no payload byte passes while discarding
    a_discard_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && overflowed_reg) |-> !(res_valid && !res_end))
        else $error("payload passed during discard");

    // line counters stay within their limits
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_payload_reg ?
            (char_count_reg <= lpld_pkg::CNT_W'(lpld_pkg::MAX_PAYLOAD)) :
            (char_count_reg <= lpld_pkg::CNT_W'(lpld_pkg::MAX_LEN_CHARS))))
        else $error("char count beyond limit");
`endif

endmodule

`default_nettype wire
